// File: rtl/sha1_pkg.sv
// Shared types, constants and control structs for the SHA-1 engine.
// Used by the controller, the datapath and the top level.
`default_nettype none

package sha1_pkg;

  // Initial chaining words.
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam int          NumRounds = 80;
  localparam logic [6:0]  LastRound = 7'(NumRounds - 1);
  localparam logic [6:0]  Phase1Start = 7'd20;
  localparam logic [6:0]  Phase2Start = 7'd40;
  localparam logic [6:0]  Phase3Start = 7'd60;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;
  localparam logic [5:0]  LastPos = 6'd63;
  localparam logic [2:0]  LastIdx = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_80,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic       absorb;
    bsel_t      bsel;
    logic       snap_len;
    logic       load_work;
    logic       round_en;
    phase_t     phase;
    logic       add_chain;
    logic       init_chain;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill_pos;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/sha1_if.sv
// Valid/ready channel interfaces for the SHA-1 engine: byte input and digest output.
// No dependencies.
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/sha1_hash_engine.sv
// SHA-1 hash engine top level: joins the controller and the datapath to the channels.
// Depends on sha1_pkg, sha1_if, sha1_ctrl and sha1_datapath.
//
//   Channel   Direction  Payload                                 Moves per transfer
//   in_ch     sink       kind, data_byte                         one message byte or finish
//   out_ch    source     digest_word, word_index, last_word      one digest word
//
// A data byte is absorbed when it is taken; the byte that completes a 64-byte block also
// starts a compression (80 rounds of the single round unit, then the chaining add; the working
// registers load in the byte's own cycle). A finish is followed by the padding bytes, a switch
// to the length bytes and a compression for each padded block, then the digest words in
// order.
// Synchronous active-low reset loads the initial chaining words and a zero length.
// No input is taken during padding, compression or digest output; a stalled output
// holds its word until the transfer completes.
`default_nettype none

module sha1_hash_engine (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  sha1_pkg::dp_cmd_t  cmd;
  sha1_pkg::dp_stat_t stat;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_kind    (in_ch.kind),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (out_ch.word_index),
    .last_word  (out_ch.last_word),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .stat        (stat),
    .digest_word (out_ch.digest_word)
  );

endmodule

`default_nettype wire

// File: rtl/sha1_datapath.sv
// SHA-1 datapath: message window, bit-length counter, working and chaining registers.
// Depends on sha1_pkg; driven by sha1_ctrl through dp_cmd_t.
`default_nettype none

module sha1_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha1_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]        data_byte,
  output sha1_pkg::dp_stat_t     stat,
  output logic [31:0]            digest_word
);

  logic [31:0] win_r [0:15];
  logic [31:0] win_nxt [0:15];
  logic [31:0] h_r [0:4];
  logic [31:0] h_nxt [0:4];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [60:0] len_r, len_nxt;   // bit length divided by eight
  logic [63:0] snap_r, snap_nxt;
  logic [7:0]  byte_in;
  logic [31:0] f_val, k_val, t_val, sched_new;

  always_comb begin
    case (cmd.bsel)
      sha1_pkg::BSEL_DATA: byte_in = data_byte;
      sha1_pkg::BSEL_80:   byte_in = sha1_pkg::PadByte;
      sha1_pkg::BSEL_ZERO: byte_in = 8'h00;
      sha1_pkg::BSEL_LEN:  byte_in = snap_r[63:56];
      default:             byte_in = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.phase)
      sha1_pkg::PH_CH: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = sha1_pkg::K0;
      end
      sha1_pkg::PH_PAR1: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1_pkg::K1;
      end
      sha1_pkg::PH_MAJ: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = sha1_pkg::K2;
      end
      sha1_pkg::PH_PAR2: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1_pkg::K3;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1_pkg::K3;
      end
    endcase
  end

  // The window holds the next sixteen schedule words; word zero is used this round.
  assign sched_new = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + win_r[0] + k_val;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (cmd.absorb) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i + 1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], byte_in};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[15] = {sched_new[30:0], sched_new[31]};
    end
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (cmd.load_work) begin
      a_nxt = h_r[0];
      b_nxt = h_r[1];
      c_nxt = h_r[2];
      d_nxt = h_r[3];
      e_nxt = h_r[4];
    end else if (cmd.round_en) begin
      a_nxt = t_val;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      h_nxt[i] = h_r[i];
    end
    len_nxt = len_r;
    snap_nxt = snap_r;
    if (cmd.absorb) begin
      len_nxt = len_r + 61'd1;
    end
    if (cmd.snap_len) begin
      snap_nxt = {len_r, 3'b000};
    end else if (cmd.absorb && cmd.bsel == sha1_pkg::BSEL_LEN) begin
      snap_nxt = {snap_r[55:0], 8'h00};
    end
    if (cmd.add_chain) begin
      h_nxt[0] = h_r[0] + a_r;
      h_nxt[1] = h_r[1] + b_r;
      h_nxt[2] = h_r[2] + c_r;
      h_nxt[3] = h_r[3] + d_r;
      h_nxt[4] = h_r[4] + e_r;
    end
    if (cmd.init_chain) begin
      h_nxt[0] = sha1_pkg::Iv0;
      h_nxt[1] = sha1_pkg::Iv1;
      h_nxt[2] = sha1_pkg::Iv2;
      h_nxt[3] = sha1_pkg::Iv3;
      h_nxt[4] = sha1_pkg::Iv4;
      len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= sha1_pkg::Iv0;
      h_r[1] <= sha1_pkg::Iv1;
      h_r[2] <= sha1_pkg::Iv2;
      h_r[3] <= sha1_pkg::Iv3;
      h_r[4] <= sha1_pkg::Iv4;
      len_r  <= '0;
    end else begin
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= h_nxt[i];
      end
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      win_r[i] <= win_nxt[i];
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    snap_r <= snap_nxt;
  end

  always_comb begin
    case (cmd.out_idx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      3'd4:    digest_word = h_r[4];
      default: digest_word = h_r[0];
    endcase
  end

  assign stat.fill_pos = len_r[5:0];

endmodule

`default_nettype wire

// File: rtl/sha1_ctrl.sv
// SHA-1 controller: sequences byte intake, padding, compression rounds and digest output.
// Depends on sha1_pkg; commands sha1_datapath through dp_cmd_t.
`default_nettype none

module sha1_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              word_index,
  output logic                    last_word,
  input  wire sha1_pkg::dp_stat_t stat,
  output sha1_pkg::dp_cmd_t       cmd
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::state_t ret_r, ret_nxt;   // where to resume after a compression
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       block_full;

  assign block_full = (stat.fill_pos == sha1_pkg::LastPos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      ret_r   <= sha1_pkg::ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.bsel  = sha1_pkg::BSEL_DATA;
    cmd.out_idx = idx_r;

    if (rnd_r < sha1_pkg::Phase1Start) begin
      cmd.phase = sha1_pkg::PH_CH;
    end else if (rnd_r < sha1_pkg::Phase2Start) begin
      cmd.phase = sha1_pkg::PH_PAR1;
    end else if (rnd_r < sha1_pkg::Phase3Start) begin
      cmd.phase = sha1_pkg::PH_MAJ;
    end else begin
      cmd.phase = sha1_pkg::PH_PAR2;
    end

    case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_kind) begin
            cmd.absorb = 1'b1;
            if (block_full) begin
              cmd.load_work = 1'b1;
              rnd_nxt   = '0;
              ret_nxt   = sha1_pkg::ST_IDLE;
              state_nxt = sha1_pkg::ST_ROUND;
            end
          end else begin
            cmd.snap_len = 1'b1;
            state_nxt = sha1_pkg::ST_PAD80;
          end
        end
      end
      sha1_pkg::ST_PAD80: begin
        cmd.absorb = 1'b1;
        cmd.bsel   = sha1_pkg::BSEL_80;
        if (block_full) begin
          cmd.load_work = 1'b1;
          rnd_nxt   = '0;
          ret_nxt   = sha1_pkg::ST_PADZ;
          state_nxt = sha1_pkg::ST_ROUND;
        end else begin
          state_nxt = sha1_pkg::ST_PADZ;
        end
      end
      sha1_pkg::ST_PADZ: begin
        if (stat.fill_pos == sha1_pkg::LenPos) begin
          state_nxt = sha1_pkg::ST_PADLEN;
        end else begin
          cmd.absorb = 1'b1;
          cmd.bsel   = sha1_pkg::BSEL_ZERO;
          if (block_full) begin
            cmd.load_work = 1'b1;
            rnd_nxt   = '0;
            ret_nxt   = sha1_pkg::ST_PADZ;
            state_nxt = sha1_pkg::ST_ROUND;
          end
        end
      end
      sha1_pkg::ST_PADLEN: begin
        // Length bytes fill positions 56 through 63, most significant first.
        cmd.absorb = 1'b1;
        cmd.bsel   = sha1_pkg::BSEL_LEN;
        if (block_full) begin
          cmd.load_work = 1'b1;
          rnd_nxt   = '0;
          ret_nxt   = sha1_pkg::ST_OUT;
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == sha1_pkg::LastRound) begin
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
        idx_nxt   = '0;
        state_nxt = ret_r;
      end
      sha1_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx_r == sha1_pkg::LastIdx) begin
            cmd.init_chain = 1'b1;
            idx_nxt   = '0;
            state_nxt = sha1_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  assign word_index = idx_r;
  assign last_word  = (idx_r == sha1_pkg::LastIdx);

endmodule

`default_nettype wire
